[rtl/ecrs_pkg.sv]
package ecrs_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_CHUNKS_DEF  = 4;
    localparam int BLOCK_BYTES_DEF = 512;

    // Field widths.
    localparam int EXT_W   = 52;   // extent byte offset and length
    localparam int BLK_W   = 36;   // block counts of the file
    localparam int SB_W    = 43;   // start block of a range
    localparam int CNT_W   = 16;   // range length minus one
    localparam int CH_W    = 2;    // chunk index
    localparam int ST_W    = 3;    // status code
    localparam int NCH_W   = 3;    // chunk count register
    localparam int RUN_W   = 17;   // run length register
    localparam int SUM_W   = 38;   // sum of up to four chunk sizes
    localparam int RANGE_W = 6;    // ranges cut from one extent

    localparam int MAX_RANGES = 63;
    localparam int RUN_LIMIT  = 65536;
    localparam int RUN_RESET  = 8192;

    // Configuration port.
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    typedef enum logic [2:0] {
        REG_TOTAL       = 3'd0,
        REG_CHUNK_COUNT = 3'd1,
        REG_MAX_RUN     = 3'd2,
        REG_CHUNK0      = 3'd3,
        REG_CHUNK1      = 3'd4,
        REG_CHUNK2      = 3'd5,
        REG_CHUNK3      = 3'd6
    } reg_idx_t;

    typedef enum logic [ST_W-1:0] {
        ST_RANGE        = 3'd0,
        ST_MISALIGNED   = 3'd1,
        ST_NOT_COVERED  = 3'd2,
        ST_SUM_MISMATCH = 3'd3,
        ST_TOO_MANY     = 3'd4
    } status_t;

    typedef struct packed {
        logic [SB_W-1:0]  start_block;
        logic [CNT_W-1:0] count_minus_one;
        logic [CH_W-1:0]  chunk_index;
        status_t          status;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;        // take the accepted item
        logic    setup_begin;  // start of a file: clear table, start divider
        logic    build_step;   // write one chunk end entry
        logic    emit_status;  // emit a status result and latch the error
        status_t code;
        logic    step_skip;    // move on to the next chunk
        logic    step_load;    // register the range limits
        logic    clamp;        // clamp the current chunk at the end of the cut
        logic    emit_range;   // emit one range and advance
        logic    flush;        // release the held result as last, end the item
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err_latched;
        logic total_zero;
        logic setup_done;
        logic div_done;
        logic build_more;
        logic sum_mismatch;
        logic covered;
        logic misaligned;
        logic loop_end;
        logic skip;
        logic no_chunk;
        logic too_many;
        logic final_short;
        logic emit_ok;
    } sts_t;

endpackage

[rtl/ecrs_div.sv]
module ecrs_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ecrs_pkg::BLK_W-1:0] dividend,
    input  logic [ecrs_pkg::NCH_W-1:0] divisor,
    output logic                       done,
    output logic [ecrs_pkg::BLK_W-1:0] quotient,
    output logic [ecrs_pkg::NCH_W-1:0] remainder
);
    import ecrs_pkg::*;

    localparam int CNT_BITS = $clog2(BLK_W + 1);

    logic                busy_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [BLK_W-1:0]    quot_reg;
    logic [NCH_W-1:0]    rem_reg;
    logic [NCH_W:0]      trial;
    logic                fits;

    // Restoring division, one quotient bit per cycle.
    assign trial = {rem_reg, quot_reg[BLK_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(BLK_W);
        end
        else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg) begin
            if (fits) begin
                rem_reg <= NCH_W'(trial - {1'b0, divisor});
            end
            else begin
                rem_reg <= trial[NCH_W-1:0];
            end
            quot_reg <= {quot_reg[BLK_W-2:0], fits};
        end
    end

    assign done      = !busy_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

[rtl/ecrs_dpath.sv]
module ecrs_dpath #(
    parameter int MAX_CHUNKS  = ecrs_pkg::MAX_CHUNKS_DEF,
    parameter int BLOCK_BYTES = ecrs_pkg::BLOCK_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ecrs_pkg::cmd_t             cmd,
    output ecrs_pkg::sts_t             sts,
    input  logic [ecrs_pkg::EXT_W-1:0] extent_byte_offset,
    input  logic [ecrs_pkg::EXT_W-1:0] extent_byte_length,
    input  logic                       final_extent,
    input  logic [ecrs_pkg::BLK_W-1:0] total_blocks,
    input  logic [ecrs_pkg::NCH_W-1:0] chunk_count,
    input  logic [ecrs_pkg::RUN_W-1:0] max_run_blocks,
    input  logic [ecrs_pkg::BLK_W-1:0] chunk0_blocks,
    input  logic [ecrs_pkg::BLK_W-1:0] chunk1_blocks,
    input  logic [ecrs_pkg::BLK_W-1:0] chunk2_blocks,
    input  logic [ecrs_pkg::BLK_W-1:0] chunk3_blocks,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ecrs_pkg::SB_W-1:0]  start_block,
    output logic [ecrs_pkg::CNT_W-1:0] count_minus_one,
    output logic [ecrs_pkg::CH_W-1:0]  chunk_index,
    output logic [ecrs_pkg::ST_W-1:0]  status,
    output logic                       last_of_run
);
    import ecrs_pkg::*;

    // BLOCK_BYTES is a power of two.
    localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int REMAIN_W  = EXT_W - BLK_SHIFT;
    localparam logic [NCH_W-1:0] N_MAX = NCH_W'(MAX_CHUNKS);

    // Item registers.
    logic [SB_W-1:0]     sb_reg;
    logic [REMAIN_W-1:0] remain_reg;
    logic                misalign_reg;
    logic                final_reg;
    logic [RANGE_W-1:0]  ranges_reg;

    // File state.
    logic [BLK_W-1:0]    done_reg;
    logic [NCH_W-1:0]    cur_reg;
    logic [NCH_W-1:0]    cur_next;
    logic                setup_reg;
    logic                err_reg;
    logic [BLK_W-1:0]    table_reg [MAX_CHUNKS];
    logic [NCH_W-1:0]    idx_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;

    // Range limits registered between the check and the cut.
    logic [RUN_W-1:0]    a_reg;
    logic [BLK_W-1:0]    left_reg;
    logic [BLK_W-1:0]    tleft_reg;

    // Held result and output register.
    res_t                pend_reg;
    logic                pend_valid_reg;
    res_t                out_reg;
    logic                out_last_reg;
    logic                out_valid_reg;

    logic [NCH_W-1:0]    n_eff;
    logic [RUN_W-1:0]    run_eff;
    logic [BLK_W-1:0]    tab_rd;
    logic [BLK_W-1:0]    size_sel;
    logic [BLK_W-1:0]    chunk_val;
    logic                cur_ok;
    logic [RUN_W-1:0]    nlb;
    logic                c_al;
    logic                c_at;
    logic                c_lt;
    logic                emit_ok;
    logic                push;
    logic                push_last;
    logic                new_valid;
    res_t                new_res;
    logic                div_done;
    logic [BLK_W-1:0]    div_quot;
    logic [NCH_W-1:0]    div_rem;

    // Registers out of range act as the nearest legal value.
    always_comb begin
        if (chunk_count == '0) begin
            n_eff = NCH_W'(1);
        end
        else if (chunk_count > N_MAX) begin
            n_eff = N_MAX;
        end
        else begin
            n_eff = chunk_count;
        end
        if (max_run_blocks == '0) begin
            run_eff = RUN_W'(1);
        end
        else if (max_run_blocks > RUN_W'(RUN_LIMIT)) begin
            run_eff = RUN_W'(RUN_LIMIT);
        end
        else begin
            run_eff = max_run_blocks;
        end
    end

    ecrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.setup_begin),
        .dividend  (total_blocks),
        .divisor   (n_eff),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Chunk end table read at the current chunk.
    always_comb begin
        tab_rd = '0;
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            if (cur_reg == NCH_W'(i)) begin
                tab_rd = table_reg[i];
            end
        end
    end

    // Size of the chunk being added to the table.
    always_comb begin
        case (idx_reg)
            3'd0:    size_sel = chunk0_blocks;
            3'd1:    size_sel = chunk1_blocks;
            3'd2:    size_sel = chunk2_blocks;
            3'd3:    size_sel = chunk3_blocks;
            default: size_sel = '0;
        endcase
        if (chunk0_blocks == '0) begin
            chunk_val = div_quot + BLK_W'(idx_reg < div_rem);
        end
        else begin
            chunk_val = size_sel;
        end
        sum_next = sum_reg + SUM_W'(chunk_val);
    end

    assign cur_ok   = cur_reg < n_eff;
    assign cur_next = cur_ok ? cur_reg : n_eff - 1'b1;

    // Smallest of run limit, room in the chunk and room in the total.
    assign c_al = BLK_W'(a_reg) <= left_reg;
    assign c_at = BLK_W'(a_reg) <= tleft_reg;
    assign c_lt = left_reg < tleft_reg;
    always_comb begin
        if (c_al && c_at) begin
            nlb = a_reg;
        end
        else if (c_lt) begin
            nlb = left_reg[RUN_W-1:0];
        end
        else begin
            nlb = tleft_reg[RUN_W-1:0];
        end
    end

    assign emit_ok = !pend_valid_reg || !out_valid_reg || out_ready;

    always_comb begin
        new_valid = 1'b0;
        new_res   = '0;
        if (cmd.emit_status) begin
            new_valid      = 1'b1;
            new_res.status = cmd.code;
        end
        else if (cmd.emit_range) begin
            new_valid               = 1'b1;
            new_res.start_block     = sb_reg;
            new_res.count_minus_one = CNT_W'(nlb - 1'b1);
            new_res.chunk_index     = cur_reg[CH_W-1:0];
            new_res.status          = ST_RANGE;
        end
    end

    // A held result moves out when a newer one arrives or the item ends.
    assign push      = (new_valid || cmd.flush) && pend_valid_reg;
    assign push_last = cmd.flush;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ranges_reg     <= '0;
            done_reg       <= '0;
            cur_reg        <= '0;
            setup_reg      <= 1'b0;
            err_reg        <= 1'b0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            if (cmd.latch) begin
                ranges_reg <= '0;
            end
            if (cmd.setup_begin) begin
                setup_reg <= 1'b1;
                cur_reg   <= '0;
                idx_reg   <= '0;
            end
            if (cmd.build_step) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.emit_status) begin
                err_reg <= 1'b1;
            end
            if (cmd.step_skip) begin
                cur_reg <= cur_reg + 1'b1;
            end
            if (cmd.clamp) begin
                cur_reg <= cur_next;
            end
            if (cmd.emit_range) begin
                done_reg   <= done_reg + BLK_W'(nlb);
                ranges_reg <= ranges_reg + 1'b1;
            end
            if (cmd.flush && final_reg) begin
                done_reg  <= '0;
                cur_reg   <= '0;
                setup_reg <= 1'b0;
                err_reg   <= 1'b0;
            end

            if (new_valid) begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end

            if (push) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.latch) begin
            sb_reg       <= SB_W'(extent_byte_offset >> BLK_SHIFT);
            remain_reg   <= REMAIN_W'(extent_byte_length >> BLK_SHIFT);
            misalign_reg <= |extent_byte_length[BLK_SHIFT-1:0];
            final_reg    <= final_extent;
        end
        if (cmd.emit_range) begin
            sb_reg     <= sb_reg + SB_W'(nlb);
            remain_reg <= remain_reg - REMAIN_W'(nlb);
        end
        if (cmd.setup_begin) begin
            sum_reg <= '0;
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                table_reg[i] <= '0;
            end
        end
        if (cmd.build_step) begin
            sum_reg <= sum_next;
            for (int i = 0; i < MAX_CHUNKS; i++) begin
                if (idx_reg == NCH_W'(i)) begin
                    table_reg[i] <= sum_next[BLK_W-1:0];
                end
            end
        end
        if (cmd.step_load) begin
            if (REMAIN_W'(run_eff) < remain_reg) begin
                a_reg <= run_eff;
            end
            else begin
                a_reg <= remain_reg[RUN_W-1:0];
            end
            left_reg  <= tab_rd - done_reg;
            tleft_reg <= total_blocks - done_reg;
        end
        if (new_valid) begin
            pend_reg <= new_res;
        end
        if (push) begin
            out_reg      <= pend_reg;
            out_last_reg <= push_last;
        end
    end

    always_comb begin
        sts              = '0;
        sts.err_latched  = err_reg;
        sts.total_zero   = total_blocks == '0;
        sts.setup_done   = setup_reg;
        sts.div_done     = div_done;
        sts.build_more   = idx_reg < n_eff;
        sts.sum_mismatch = sum_reg != SUM_W'(total_blocks);
        sts.covered      = done_reg >= total_blocks;
        sts.misaligned   = misalign_reg;
        sts.loop_end     = (remain_reg == '0) || (done_reg >= total_blocks);
        sts.skip         = cur_ok && (done_reg >= tab_rd);
        sts.no_chunk     = !cur_ok;
        sts.too_many     = ranges_reg == RANGE_W'(MAX_RANGES);
        sts.final_short  = final_reg && (done_reg != total_blocks);
        sts.emit_ok      = emit_ok;
    end

    assign out_valid       = out_valid_reg;
    assign start_block     = out_reg.start_block;
    assign count_minus_one = out_reg.count_minus_one;
    assign chunk_index     = out_reg.chunk_index;
    assign status          = out_reg.status;
    assign last_of_run     = out_last_reg;

    // A range is never empty and never longer than its registered limit.
    a_range_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_range |-> (nlb != '0) && (nlb <= a_reg))
        else $error("range length out of bounds");

    // No result is produced while a held result has nowhere to go.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_range || cmd.emit_status || cmd.flush) |-> emit_ok)
        else $error("result produced while output is blocked");

    // Closing the last extent of a file starts the next file from scratch.
    a_file_reset: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush && final_reg |=> (done_reg == '0) && !setup_reg && !err_reg)
        else $error("file state not cleared after final extent");

endmodule

[rtl/ecrs_ctrl.sv]
module ecrs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ecrs_pkg::sts_t sts,
    output ecrs_pkg::cmd_t cmd
);
    import ecrs_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DISPATCH = 10'b0000000010,
        S_DIVIDE   = 10'b0000000100,
        S_BUILD    = 10'b0000001000,
        S_VERIFY   = 10'b0000010000,
        S_ENTRY    = 10'b0000100000,
        S_STEP     = 10'b0001000000,
        S_EMIT     = 10'b0010000000,
        S_CLOSE    = 10'b0100000000,
        S_FLUSH    = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.err_latched || sts.total_zero) begin
                    state_next = S_FLUSH;
                end
                else if (!sts.setup_done) begin
                    cmd.setup_begin = 1'b1;
                    state_next      = S_DIVIDE;
                end
                else begin
                    state_next = S_ENTRY;
                end
            end
            S_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = S_BUILD;
                end
            end
            S_BUILD: begin
                if (sts.build_more) begin
                    cmd.build_step = 1'b1;
                end
                else begin
                    state_next = S_VERIFY;
                end
            end
            S_VERIFY: begin
                if (!sts.sum_mismatch) begin
                    state_next = S_ENTRY;
                end
                else if (sts.emit_ok) begin
                    cmd.emit_status = 1'b1;
                    cmd.code        = ST_SUM_MISMATCH;
                    state_next      = S_FLUSH;
                end
            end
            S_ENTRY: begin
                if (sts.covered) begin
                    state_next = S_CLOSE;
                end
                else if (!sts.misaligned) begin
                    state_next = S_STEP;
                end
                else if (sts.emit_ok) begin
                    cmd.emit_status = 1'b1;
                    cmd.code        = ST_MISALIGNED;
                    state_next      = S_FLUSH;
                end
            end
            S_STEP: begin
                if (sts.loop_end) begin
                    cmd.clamp  = 1'b1;
                    state_next = S_CLOSE;
                end
                else if (sts.skip) begin
                    cmd.step_skip = 1'b1;
                end
                else if (sts.no_chunk || sts.too_many) begin
                    if (sts.emit_ok) begin
                        cmd.emit_status = 1'b1;
                        cmd.code        = sts.no_chunk ? ST_SUM_MISMATCH : ST_TOO_MANY;
                        cmd.clamp       = 1'b1;
                        state_next      = S_FLUSH;
                    end
                end
                else begin
                    cmd.step_load = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.emit_ok) begin
                    cmd.emit_range = 1'b1;
                    state_next     = S_STEP;
                end
            end
            S_CLOSE: begin
                if (!sts.final_short) begin
                    state_next = S_FLUSH;
                end
                else if (sts.emit_ok) begin
                    cmd.emit_status = 1'b1;
                    cmd.code        = ST_NOT_COVERED;
                    state_next      = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (sts.emit_ok) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

    // Every accepted item is looked at in the following cycle.
    a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DISPATCH)
        else $error("accepted item not dispatched");

endmodule

[rtl/extent_to_copy_range_splitter.sv]
// Extent to copy range splitter.
//
// Input channel (in_valid/in_ready): one file extent per item, a physical
// byte offset, a byte length and a flag that marks the last extent of the
// file. Output channel (out_valid/out_ready): copy ranges (start block,
// length minus one, chunk index) and status results; last_of_run marks the
// last result that one extent caused. An extent that causes nothing gives
// no result at all.
// The block works on one extent at a time. Each range of an extent that
// is cut takes a limit check, then the cut, and every chunk boundary
// passed takes a step of its own. The first extent of a file also waits
// while the divider runs and the chunk end table is built; the divider
// finds one quotient bit at a time.
// Results pass through a one-entry hold stage and an output register, so
// a new extent is taken while the last result still waits at the output.
// When the receiver stalls, the cut stops at the next result and resumes
// when out_ready returns. Reset empties both stages and starts a new file;
// the configuration registers return to their reset values.
module extent_to_copy_range_splitter #(
    parameter int MAX_CHUNKS  = ecrs_pkg::MAX_CHUNKS_DEF,
    parameter int BLOCK_BYTES = ecrs_pkg::BLOCK_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ecrs_pkg::APB_AW-1:0] paddr,
    input  logic [ecrs_pkg::APB_DW-1:0] pwdata,
    output logic [ecrs_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    // Extent items.
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ecrs_pkg::EXT_W-1:0]  extent_byte_offset,
    input  logic [ecrs_pkg::EXT_W-1:0]  extent_byte_length,
    input  logic                        final_extent,
    // Result items.
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ecrs_pkg::SB_W-1:0]   start_block,
    output logic [ecrs_pkg::CNT_W-1:0]  count_minus_one,
    output logic [ecrs_pkg::CH_W-1:0]   chunk_index,
    output logic [ecrs_pkg::ST_W-1:0]   status,
    output logic                        last_of_run
);
    import ecrs_pkg::*;

    logic [BLK_W-1:0] total_reg;
    logic [NCH_W-1:0] chunk_count_reg;
    logic [RUN_W-1:0] max_run_reg;
    logic [BLK_W-1:0] chunk0_reg;
    logic [BLK_W-1:0] chunk1_reg;
    logic [BLK_W-1:0] chunk2_reg;
    logic [BLK_W-1:0] chunk3_reg;
    logic             wr_en;
    reg_idx_t         reg_idx;
    cmd_t             cmd;
    sts_t             sts;

    // Registers sit at eight-byte steps; the low address bits are ignored.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:3]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            total_reg       <= '0;
            chunk_count_reg <= NCH_W'(1);
            max_run_reg     <= RUN_W'(RUN_RESET);
            chunk0_reg      <= '0;
            chunk1_reg      <= '0;
            chunk2_reg      <= '0;
            chunk3_reg      <= '0;
        end
        else if (wr_en) begin
            case (reg_idx)
                REG_TOTAL:       total_reg       <= pwdata[BLK_W-1:0];
                REG_CHUNK_COUNT: chunk_count_reg <= pwdata[NCH_W-1:0];
                REG_MAX_RUN:     max_run_reg     <= pwdata[RUN_W-1:0];
                REG_CHUNK0:      chunk0_reg      <= pwdata[BLK_W-1:0];
                REG_CHUNK1:      chunk1_reg      <= pwdata[BLK_W-1:0];
                REG_CHUNK2:      chunk2_reg      <= pwdata[BLK_W-1:0];
                REG_CHUNK3:      chunk3_reg      <= pwdata[BLK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TOTAL:       prdata = APB_DW'(total_reg);
            REG_CHUNK_COUNT: prdata = APB_DW'(chunk_count_reg);
            REG_MAX_RUN:     prdata = APB_DW'(max_run_reg);
            REG_CHUNK0:      prdata = APB_DW'(chunk0_reg);
            REG_CHUNK1:      prdata = APB_DW'(chunk1_reg);
            REG_CHUNK2:      prdata = APB_DW'(chunk2_reg);
            REG_CHUNK3:      prdata = APB_DW'(chunk3_reg);
            default:         prdata = '0;
        endcase
    end

    // The controller sequences setup, checks and cuts; the datapath holds
    // the file state, the chunk end table and the result stages.
    ecrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ecrs_dpath #(
        .MAX_CHUNKS  (MAX_CHUNKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .extent_byte_offset (extent_byte_offset),
        .extent_byte_length (extent_byte_length),
        .final_extent       (final_extent),
        .total_blocks       (total_reg),
        .chunk_count        (chunk_count_reg),
        .max_run_blocks     (max_run_reg),
        .chunk0_blocks      (chunk0_reg),
        .chunk1_blocks      (chunk1_reg),
        .chunk2_blocks      (chunk2_reg),
        .chunk3_blocks      (chunk3_reg),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .start_block        (start_block),
        .count_minus_one    (count_minus_one),
        .chunk_index        (chunk_index),
        .status             (status),
        .last_of_run        (last_of_run)
    );

endmodule
